[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the source hit-count blocklist.
// No dependencies; synthesis builds define SYNTH so the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/shc_pkg.sv]
// Shared types and constants of the source hit-count blocklist.
// No dependencies; used by the controller, the datapath and the top level.
package shc_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int COUNT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 8'd1;
  localparam logic [COUNT_W-1:0] THR_RESET  = 8'd4;

  // Lookup outcome reported with every result
  typedef enum logic [1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_INSERTED = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the incoming packet, restart the scan
    logic advance;  // step to the next entry
    logic hit;      // bump the count of the matched entry
    logic insert;   // write a new entry at the fill level
    logic full;     // report an untracked source
    logic emit;     // move the pending result to the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic match;    // entry under compare holds the packet's address
    logic last;     // entry under compare is the last valid one
    logic room;     // table has a free entry
  } status_t;

endpackage

[design/shc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the entry table of the blocklist.
module shc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/shc_controller.sv]
// Sequencer of the blocklist: accept, scan the table entry by entry, resolve, deliver.
// Depends on shc_pkg for the command and status structs.
module shc_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  shc_pkg::status_t stat_i,
  output shc_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = S_DONE;
        end else if (stat_i.last) begin
          cmd_o.insert = stat_i.room;
          cmd_o.full   = !stat_i.room;
          state_d      = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold or clear the output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/shc_datapath.sv]
// Datapath of the blocklist: threshold, fill level, entry memory, compare and result registers.
// Depends on shc_pkg and shc_ram.
module shc_datapath #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [shc_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic [shc_pkg::ADDR_W-1:0]   src_addr_i,
  input  logic [shc_pkg::PORT_W-1:0]   src_port_i,
  input  shc_pkg::cmd_t                cmd_i,
  output shc_pkg::status_t             stat_o,
  output logic                         block_now_o,
  output logic [shc_pkg::ADDR_W-1:0]   rule_addr_o,
  output logic [shc_pkg::PORT_W-1:0]   rule_port_o,
  output logic [1:0]                   lookup_status_o,
  output logic [shc_pkg::COUNT_W-1:0]  hit_count_o
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W  = $bits(shc_pkg::entry_t);

  logic [shc_pkg::COUNT_W-1:0] thr_q;
  logic [FILL_W-1:0]           fill_q;
  logic [IDX_W-1:0]            idx_q;
  logic [shc_pkg::ADDR_W-1:0]  key_addr_q;
  logic [shc_pkg::PORT_W-1:0]  key_port_q;

  logic                        res_block_q;
  shc_pkg::status_e            res_status_q;
  logic [shc_pkg::COUNT_W-1:0] res_count_q;

  logic                        out_block_q;
  logic [shc_pkg::ADDR_W-1:0]  out_addr_q;
  logic [shc_pkg::PORT_W-1:0]  out_port_q;
  shc_pkg::status_e            out_status_q;
  logic [shc_pkg::COUNT_W-1:0] out_count_q;

  logic [FILL_W-1:0]           idx_nxt;
  logic [ENT_W-1:0]            rdata;
  shc_pkg::entry_t             rd_entry;
  shc_pkg::entry_t             wr_entry;
  logic [shc_pkg::COUNT_W-1:0] cnt_inc;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [IDX_W-1:0]            ram_raddr;

  // Entry memory
  shc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign rd_entry = shc_pkg::entry_t'(rdata);
  assign idx_nxt  = FILL_W'(idx_q) + FILL_W'(1);

  // Compare the entry read last cycle against the packet's address
  assign stat_o.match = (FILL_W'(idx_q) < fill_q) && (rd_entry.addr == key_addr_q);
  assign stat_o.last  = (idx_nxt >= fill_q);
  assign stat_o.room  = (fill_q != FILL_W'(TABLE_DEPTH));

  // Saturating count increment
  assign cnt_inc = (rd_entry.count == shc_pkg::COUNT_MAX) ? shc_pkg::COUNT_MAX
                 : rd_entry.count + shc_pkg::COUNT_W'(1);

  // Read the first entry while idle, the next one while scanning
  assign ram_raddr = cmd_i.advance ? idx_nxt[IDX_W-1:0] : '0;

  // Write back a bumped count or a new entry
  assign ram_we         = cmd_i.hit || cmd_i.insert;
  assign ram_waddr      = cmd_i.hit ? idx_q : fill_q[IDX_W-1:0];
  assign wr_entry.addr  = key_addr_q;
  assign wr_entry.count = cmd_i.hit ? cnt_inc : shc_pkg::COUNT_ONE;

  // Control registers: threshold, fill level, scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= shc_pkg::THR_RESET;
      fill_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.insert) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.advance) begin
        idx_q <= idx_nxt[IDX_W-1:0];
      end
    end
  end

  // Capture the packet, resolve the result, load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_addr_q <= src_addr_i;
      key_port_q <= src_port_i;
    end
    if (cmd_i.hit) begin
      res_block_q  <= (cnt_inc > thr_q);
      res_status_q <= shc_pkg::STATUS_FOUND;
      res_count_q  <= cnt_inc;
    end else if (cmd_i.insert) begin
      res_block_q  <= 1'b0;
      res_status_q <= shc_pkg::STATUS_INSERTED;
      res_count_q  <= shc_pkg::COUNT_ONE;
    end else if (cmd_i.full) begin
      res_block_q  <= 1'b0;
      res_status_q <= shc_pkg::STATUS_FULL;
      res_count_q  <= '0;
    end
    if (cmd_i.emit) begin
      out_block_q  <= res_block_q;
      out_addr_q   <= res_block_q ? key_addr_q : '0;
      out_port_q   <= res_block_q ? key_port_q : '0;
      out_status_q <= res_status_q;
      out_count_q  <= res_count_q;
    end
  end

  assign block_now_o     = out_block_q;
  assign rule_addr_o     = out_addr_q;
  assign rule_port_o     = out_port_q;
  assign lookup_status_o = out_status_q;
  assign hit_count_o     = out_count_q;

endmodule

[design/source_hit_count_blocklist.sv]
// Top level of the source hit-count blocklist: controller, datapath and assertions.
// Depends on shc_pkg, shc_controller, shc_datapath and assert_macros.svh.
//
// Each packet's source address is looked up in a table of up to TABLE_DEPTH
// addresses held in one memory with a single registered read port; the scan
// reads one entry per cycle, stopping at the first entry that matches or, on a
// miss, after the last stored address, the fill level being the number of
// addresses stored so far. No new packet is accepted before the finished
// result moves to the output register; it sits there and the next
// packet is accepted while it waits. A known address has its count
// raised (saturating at 255) and is flagged for blocking once the count
// exceeds hit_threshold; a new address is stored with count 1 until the table
// is full, after which new addresses are reported untracked. No table clear is
// needed after reset: entries above the fill level are never compared.
`include "assert_macros.svh"
module source_hit_count_blocklist #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] src_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        block_now_o,
  output logic [31:0] rule_addr_o,
  output logic [15:0] rule_port_o,
  output logic [1:0]  lookup_status_o,
  output logic [7:0]  hit_count_o
);

  shc_pkg::cmd_t    cmd;
  shc_pkg::status_t stat;
  logic [2:0]       resolve_vec;
  logic             result_found;

  // Sequencer
  shc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Table and result path
  shc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .src_addr_i      (src_addr_i),
    .src_port_i      (src_port_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .block_now_o     (block_now_o),
    .rule_addr_o     (rule_addr_o),
    .rule_port_o     (rule_port_o),
    .lookup_status_o (lookup_status_o),
    .hit_count_o     (hit_count_o)
  );

  // Resolve commands of one scan
  assign resolve_vec = {cmd.hit, cmd.insert, cmd.full};

  // Result on the output reports an existing entry
  assign result_found = (lookup_status_o == shc_pkg::STATUS_FOUND);

  `ASSERT_IMPLIES(a_one_resolve, clk_i, rst_ni, 1'b1, $onehot0(resolve_vec))
  `ASSERT_IMPLIES(a_insert_room, clk_i, rst_ni, cmd.insert, stat.room)
  `ASSERT_IMPLIES(a_block_found, clk_i, rst_ni, out_valid_o && block_now_o, result_found)
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

[dv/source_hit_count_blocklist_tb.sv]
// Self-checking testbench for the source hit-count blocklist top level.
// Depends on shc_pkg and source_hit_count_blocklist; drives packets and
// threshold writes, and predicts every result in a small scoreboard class.
module source_hit_count_blocklist_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 128;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PACKETS = 106;

  // One expected or observed lookup result
  typedef struct {
    logic                        block;
    logic [shc_pkg::ADDR_W-1:0]  addr;
    logic [shc_pkg::PORT_W-1:0]  port;
    shc_pkg::status_e            status;
    logic [shc_pkg::COUNT_W-1:0] count;
  } verdict_t;

  // Mirror of the source table with the queue of verdicts still owed
  class blocklist_scoreboard;
    logic [shc_pkg::COUNT_W-1:0] hit_threshold;
    logic [shc_pkg::ADDR_W-1:0]  known_addr[TABLE_DEPTH];
    logic [shc_pkg::COUNT_W-1:0] known_count[TABLE_DEPTH];
    int unsigned                 fill_level;
    verdict_t                    pending_verdicts[$];
    int unsigned                 mismatches;

    function new();
      hit_threshold = shc_pkg::THR_RESET;
      fill_level    = 0;
      mismatches    = 0;
    endfunction

    // Look up one accepted packet, update the table and queue its verdict
    function void admit_packet(logic [shc_pkg::ADDR_W-1:0] addr,
                               logic [shc_pkg::PORT_W-1:0] port);
      verdict_t v;
      bit       found;
      found = 1'b0;
      v = '{block: 1'b0, addr: '0, port: '0, status: shc_pkg::STATUS_FULL, count: '0};
      for (int k = 0; k < fill_level; k++) begin
        if (!found && known_addr[k] == addr) begin
          found = 1'b1;
          if (known_count[k] != shc_pkg::COUNT_MAX) known_count[k]++;
          v.status = shc_pkg::STATUS_FOUND;
          v.count  = known_count[k];
          if (v.count > hit_threshold) begin
            v.block = 1'b1;
            v.addr  = addr;
            v.port  = port;
          end
        end
      end
      // Insert an unknown source while there is room; a fresh entry never blocks
      if (!found && fill_level < TABLE_DEPTH) begin
        known_addr[fill_level]  = addr;
        known_count[fill_level] = shc_pkg::COUNT_ONE;
        fill_level++;
        v.status = shc_pkg::STATUS_INSERTED;
        v.count  = shc_pkg::COUNT_ONE;
      end
      pending_verdicts.push_back(v);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Compare one observed result with the oldest verdict owed
    task check_verdict(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, addr %h", got.addr));
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.block !== want.block)
        report_mismatch($sformatf("block_now %b, want %b", got.block, want.block));
      if (got.addr !== want.addr)
        report_mismatch($sformatf("rule_addr %h, want %h", got.addr, want.addr));
      if (got.port !== want.port)
        report_mismatch($sformatf("rule_port %h, want %h", got.port, want.port));
      if (got.status !== want.status)
        report_mismatch($sformatf("lookup_status %0d, want %0d", got.status, want.status));
      if (got.count !== want.count)
        report_mismatch($sformatf("hit_count %0d, want %0d", got.count, want.count));
    endtask
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [7:0]        cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [31:0]       src_addr_i  = '0;
  logic [15:0]       src_port_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              block_now_o;
  logic [31:0]       rule_addr_o;
  logic [15:0]       rule_port_o;
  logic [1:0]        lookup_status_o;
  logic [7:0]        hit_count_o;

  blocklist_scoreboard        sb = new();
  logic [shc_pkg::ADDR_W-1:0] seen_sources[$];
  logic [shc_pkg::ADDR_W-1:0] hot_source = 32'hC0A8_0107;
  bit                         calm_stretch = 1'b0;
  int unsigned                cycle_count = 0;

  source_hit_count_blocklist #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .src_addr_i, .src_port_i,
    .out_valid_o, .out_stall_i, .block_now_o, .rule_addr_o, .rule_port_o,
    .lookup_status_o, .hit_count_o
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random except in the calm stretch
  always @(negedge clk_i) begin
    out_stall_i <= !calm_stretch && ($urandom_range(0, 99) < 9);
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    verdict_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.block  = block_now_o;
      got.addr   = rule_addr_o;
      got.port   = rule_port_o;
      got.status = shc_pkg::status_e'(lookup_status_o);
      got.count  = hit_count_o;
      sb.check_verdict(got);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[source_hit_count_blocklist] ERROR");
      $finish;
    end
  end

  // Offer one packet, hold it until the transfer, return at the next falling edge
  task send_packet(logic [shc_pkg::ADDR_W-1:0] addr, logic [shc_pkg::PORT_W-1:0] port);
    while (!calm_stretch && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    src_addr_i <= addr;
    src_port_i <= port;
    do @(posedge clk_i); while (in_stall_o);
    sb.admit_packet(addr, port);
    @(negedge clk_i);
  endtask

  // Drain the block, then write the threshold register
  task set_hit_threshold(logic [7:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.hit_threshold = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly the hot source and known sources, with fresh ones to fill the table
  task run_random_phase(int unsigned packets);
    logic [shc_pkg::ADDR_W-1:0] addr;
    int unsigned                pick;
    for (int i = 0; i < packets; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        addr = hot_source;
      end else if (pick < 78) begin
        addr = seen_sources[$urandom_range(0, seen_sources.size() - 1)];
      end else begin
        addr = $urandom();
        seen_sources.push_back(addr);
      end
      send_packet(addr, 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    logic [7:0] phase_threshold[RANDOM_PHASES];
    phase_threshold = '{8'd1, 8'd254, 8'd0, 8'd255, 8'd37, 8'd100, 8'd2, 8'd254};
    phase_threshold[4] = 8'($urandom_range(0, 255));
    seen_sources = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0107, 32'h0A00_0001};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, then repeated hits past the reset threshold
    send_packet(32'h0000_0000, 16'h0000);
    send_packet(32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 6; i++)
      send_packet(hot_source, (i % 2) ? 16'hFFFF : 16'(i));
    send_packet(32'h0000_0000, 16'h8001);

    // Threshold zero: a fresh insert still does not block, a second hit does
    set_hit_threshold(8'd0);
    send_packet(32'h0A00_0001, 16'h1234);
    send_packet(32'h0A00_0001, 16'h4321);
    send_packet(32'hFFFF_FFFF, 16'hFFFF);

    // Threshold at the top: nothing can block
    set_hit_threshold(8'd255);
    send_packet(hot_source, 16'hFFFF);
    send_packet(32'h0000_0000, 16'h0000);

    // Random phases; the table fills and the hot source saturates along the way
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_hit_threshold(phase_threshold[p]);
      calm_stretch = (p == 2);
      run_random_phase(PHASE_PACKETS);
    end
    calm_stretch = 1'b0;

    // Drain and let the block settle
    in_valid_i <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (TABLE_DEPTH + 4) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("[source_hit_count_blocklist] OK");
    end else begin
      $display("[source_hit_count_blocklist] ERROR");
    end
    $finish;
  end

endmodule
